// ===== design/ghash_pkg.sv =====
`timescale 1ns / 1ps

package ghash_pkg;

    // field and port widths
    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int COUNT_W    = 64;
    localparam int NBYTES_W   = 5;
    localparam int ACTION_W   = 2;
    localparam int BITS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 128;
    localparam int BLOCK_BYTES = BLOCK_W / 8;

    // item kinds carried on s_tuser; the fourth code is ignored
    typedef enum logic [ACTION_W-1:0] {
        ACT_AAD    = 2'd0,
        ACT_TEXT   = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_HI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MASK_HI = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MASK_LO = 2'd3;

    // reverse bit order of a 128-bit word
    function automatic logic [BLOCK_W-1:0] bit_rev(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[i] = x[BLOCK_W-1-i];
        end
        return r;
    endfunction

    // keep the leading n bytes of a block (byte 0 in the top bits), n >= 16 keeps all
    function automatic logic [BLOCK_W-1:0] byte_mask(input logic [NBYTES_W-1:0] n);
        logic [BLOCK_W-1:0] m;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            m[BLOCK_W-1-8*j -: 8] = (NBYTES_W'(j) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // GF(2^128) product in GCM bit order, modulo x^128 + x^7 + x^2 + x + 1
    function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
                                                  input logic [BLOCK_W-1:0] h);
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   b;
        logic [BLOCK_W-1:0]   r;
        logic [2*BLOCK_W-2:0] p;
        logic [BLOCK_W-2:0]   hi;
        logic [BLOCK_W+5:0]   t;
        logic [5:0]           g;
        a = bit_rev(x);
        b = bit_rev(h);
        p = '0;
        // carry-less partial products, one per multiplier bit
        for (int i = 0; i < BLOCK_W; i++) begin
            if (a[i]) begin
                p = p ^ ({{(BLOCK_W-1){1'b0}}, b} << i);
            end
        end
        // first fold of the upper half
        hi = p[2*BLOCK_W-2:BLOCK_W];
        t  = {7'b0, hi} ^ ({7'b0, hi} << 1) ^ ({7'b0, hi} << 2) ^ ({7'b0, hi} << 7);
        // second fold of the few bits that spill past degree 127
        g  = t[BLOCK_W+5:BLOCK_W];
        r  = p[BLOCK_W-1:0] ^ t[BLOCK_W-1:0]
           ^ {{(BLOCK_W-6){1'b0}}, g}
           ^ ({{(BLOCK_W-6){1'b0}}, g} << 1)
           ^ ({{(BLOCK_W-6){1'b0}}, g} << 2)
           ^ ({{(BLOCK_W-6){1'b0}}, g} << 7);
        return bit_rev(r);
    endfunction

endpackage

// ===== design/gcm_ghash_tag_engine_unit.sv =====
`timescale 1ns / 1ps

// GHASH tag engine for GCM. Blocks stream in at one per cycle, a throughput set by the
// combinational GF(2^128) multiplier that closes the accumulator loop, unless a finish
// in the input stage waits for a busy tag output. Each is an AAD or ciphertext block
// (kind on s_tuser) whose bytes past the valid count are zeroed, XORed into the 128-bit
// accumulator and multiplied by the hash key H in GF(2^128). A finish transfer folds in
// the length block (AAD bits, ciphertext bits, 64 bits each, big-endian), emits GHASH
// XOR the tag mask on the m_ side and clears the accumulator and bit counters for the
// next message; the tag is registered from the input stage into the output register
// once the output is free. Unused-kind items and zero-byte blocks are dropped. The user
// must write key and mask registers only between messages; the block does not enforce it.
module gcm_ghash_tag_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [63:0] data_hi, [127:64] data_lo, [132:128] valid_bytes, rest zero
    input  logic [ghash_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] action
    input  logic [ghash_pkg::ACTION_W-1:0]      s_tuser,
    // tag stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] tag_hi, [127:64] tag_lo
    output logic [ghash_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [ghash_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [ghash_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ghash_pkg::*;

    // configuration
    logic [HALF_W-1:0]  key_hi_reg, key_lo_reg, mask_hi_reg, mask_lo_reg;

    // input stage
    logic               pipe_valid_reg, pipe_valid_next;
    action_t            pipe_action_reg, pipe_action_next;
    logic [BLOCK_W-1:0] pipe_data_reg, pipe_data_next;
    logic [BITS_W-1:0]  pipe_bits_reg, pipe_bits_next;

    // hash state
    logic [BLOCK_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] aad_cnt_reg, aad_cnt_next;
    logic [COUNT_W-1:0] text_cnt_reg, text_cnt_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] out_tag_reg, out_tag_next;

    logic [ACTION_W-1:0] in_action;
    logic [HALF_W-1:0]   in_hi, in_lo;
    logic [NBYTES_W-1:0] in_nbytes, in_nsat;
    logic                in_is_block, in_keep, s_xfer;
    logic                pipe_is_fin, out_free, pipe_fire;
    logic [BLOCK_W-1:0]  mul_in, mul_out;

    // unpack the input transfer
    assign in_action = s_tuser;
    assign in_hi     = s_tdata[HALF_W-1:0];
    assign in_lo     = s_tdata[BLOCK_W-1:HALF_W];
    assign in_nbytes = s_tdata[BLOCK_W+NBYTES_W-1:BLOCK_W];
    assign in_nsat   = (in_nbytes > NBYTES_W'(BLOCK_BYTES)) ? NBYTES_W'(BLOCK_BYTES)
                                                             : in_nbytes;
    assign in_is_block = (in_action == ACT_AAD) || (in_action == ACT_TEXT);
    assign in_keep     = (in_action == ACT_FINISH) || (in_is_block && (in_nsat != '0));

    // pipeline advance
    assign pipe_is_fin = (pipe_action_reg == ACT_FINISH);
    assign out_free    = !out_valid_reg || m_tready;
    assign pipe_fire   = pipe_valid_reg && (!pipe_is_fin || out_free);
    assign s_tready    = !pipe_valid_reg || pipe_fire;
    assign s_xfer      = s_tvalid && s_tready;

    // input stage load
    always_comb begin
        pipe_valid_next  = pipe_valid_reg;
        pipe_action_next = pipe_action_reg;
        pipe_data_next   = pipe_data_reg;
        pipe_bits_next   = pipe_bits_reg;
        if (s_xfer) begin
            pipe_valid_next  = in_keep;
            pipe_action_next = action_t'(in_action);
            pipe_data_next   = {in_hi, in_lo} & byte_mask(in_nsat);
            pipe_bits_next   = {in_nsat, 3'b000};
        end else if (pipe_fire) begin
            pipe_valid_next = 1'b0;
        end
    end

    // accumulator update: one GF(2^128) multiply per block
    assign mul_in  = acc_reg ^ (pipe_is_fin ? {aad_cnt_reg, text_cnt_reg} : pipe_data_reg);
    assign mul_out = gf_mul(mul_in, {key_hi_reg, key_lo_reg});

    always_comb begin
        acc_next       = acc_reg;
        aad_cnt_next   = aad_cnt_reg;
        text_cnt_next  = text_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_tag_next   = out_tag_reg;
        if (pipe_fire) begin
            if (pipe_is_fin) begin
                acc_next       = '0;
                aad_cnt_next   = '0;
                text_cnt_next  = '0;
                out_valid_next = 1'b1;
                out_tag_next   = mul_out ^ {mask_hi_reg, mask_lo_reg};
            end else begin
                acc_next = mul_out;
                if (pipe_action_reg == ACT_AAD) begin
                    aad_cnt_next = aad_cnt_reg + COUNT_W'(pipe_bits_reg);
                end else begin
                    text_cnt_next = text_cnt_reg + COUNT_W'(pipe_bits_reg);
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_reg        <= '0;
            aad_cnt_reg    <= '0;
            text_cnt_reg   <= '0;
        end else begin
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
            acc_reg        <= acc_next;
            aad_cnt_reg    <= aad_cnt_next;
            text_cnt_reg   <= text_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pipe_action_reg <= pipe_action_next;
        pipe_data_reg   <= pipe_data_next;
        pipe_bits_reg   <= pipe_bits_next;
        out_tag_reg     <= out_tag_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg  <= '0;
            key_lo_reg  <= '0;
            mask_hi_reg <= '0;
            mask_lo_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_HASH_KEY_HI: key_hi_reg  <= cfg_wr_data;
                CFG_HASH_KEY_LO: key_lo_reg  <= cfg_wr_data;
                CFG_TAG_MASK_HI: mask_hi_reg <= cfg_wr_data;
                CFG_TAG_MASK_LO: mask_lo_reg <= cfg_wr_data;
                default:         key_hi_reg  <= key_hi_reg;
            endcase
        end
    end

    // tag out: tag_hi in the low half of tdata
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tag_reg[HALF_W-1:0], out_tag_reg[BLOCK_W-1:HALF_W]};

endmodule

// ===== design/ghash_checker.sv =====
`timescale 1ns / 1ps

module ghash_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ghash_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [ghash_pkg::ACTION_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ghash_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             cfg_wr_en,
    input logic [ghash_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input logic [ghash_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import ghash_pkg::*;

    // a stalled tag stays put
    a_tag_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("tag changed or dropped while stalled");

    // no tag pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("tag valid after reset");

    // input side ready right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // with the output free nothing can hold up the input stage
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no tag pending");

endmodule

bind gcm_ghash_tag_engine_unit ghash_checker u_ghash_checker (.*);
